// ===== hdl/pts_pkg.sv =====
// shared types and codes for the periodic task scheduler table
package pts_pkg;

  localparam int SLOT_W = 6;
  localparam int TIME_W = 16;

  typedef enum logic [1:0] {
    OP_CREATE   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_TICK     = 2'd2,
    OP_DISPATCH = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STS_CREATED = 3'd0,
    STS_FULL    = 3'd1,
    STS_DELETED = 3'd2,
    STS_TICKED  = 3'd3,
    STS_RUN     = 3'd4,
    STS_IDLE    = 3'd5
  } status_t;

  // classified command handed from the front end to the engine
  typedef struct packed {
    op_t               op;
    logic              slot_ok;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] delay;
  } cmd_t;

endpackage

// ===== hdl/periodic_task_scheduler_table.sv =====
// top level of the periodic task scheduler table
//
// commands enter on the s_ group: s_tuser carries the operation (create, delete,
// tick, dispatch) and s_tdata the slot, period and initial delay. results leave
// on the m_ group: m_tuser carries the status, m_tdata the task slot and m_tlast
// marks the final result of a command.
// a two-entry queue sits between the input stage and the engine, so commands
// are taken while the engine works or while a result waits in the output register.
// delete is answered from the idle state: its queued command goes straight to
// the result register. create, tick and dispatch walk the slot table one entry
// per cycle while no result stalls, through the period/countdown ram (one read
// and one write port). a tick, a full create or an empty dispatch answers once
// the walk has passed every slot; dispatch results leave one per cycle, unless
// stalled, as the walk meets ready slots, and a create stops at the first free
// slot. the engine ends each walk before it takes the next command from the queue.
// reset empties the queue, drops any pending result and frees every slot; the
// ram needs no clearing since a free slot's entry is rewritten by its create.
// when a result is due but m_tready holds the last one, the engine keeps its place
// until the result register drains; the queue then fills and s_tready drops.
module periodic_task_scheduler_table #(
  parameter int TASK_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // slot[7:0], period[23:8], delay[39:24]
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // task_slot[5:0], zero[7:6]
  output logic [2:0]  m_tuser,   // status[2:0]
  output logic        m_tlast
);
  import pts_pkg::*;

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  pts_front #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  pts_engine #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== hdl/pts_ram.sv =====
// generic single-write, registered-read ram
module pts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wa,
  input  logic [WIDTH-1:0]                        wd,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ra,
  output logic [WIDTH-1:0]                        rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

// ===== hdl/pts_front.sv =====
// input stage: accepts transactions, classifies them and queues them for the engine
module pts_front #(
  parameter int TASK_SLOTS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [39:0]   s_tdata,
  input  logic [1:0]    s_tuser,
  output logic          q_valid,
  output pts_pkg::cmd_t q_cmd,
  input  logic          q_pop
);
  import pts_pkg::*;

  cmd_t       fifo [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;
  cmd_t       cmd_in;
  logic       push;
  logic [7:0] slot_raw;

  assign slot_raw = s_tdata[7:0];

  always_comb begin
    cmd_in.op      = op_t'(s_tuser);
    cmd_in.slot_ok = ({1'b0, slot_raw} < 9'(TASK_SLOTS));
    cmd_in.slot    = slot_raw[SLOT_W-1:0];
    cmd_in.period  = s_tdata[23:8];
    cmd_in.delay   = s_tdata[39:24];
  end

  assign s_tready = (cnt != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (cnt != 2'd0);
  assign q_cmd    = fifo[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (q_pop) begin
        rptr <= ~rptr;
      end
      if (push && !q_pop) begin
        cnt <= cnt + 2'd1;
      end else if (!push && q_pop) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/pts_engine.sv =====
// back end: walks the slot table (not for delete) and drives the result register
module pts_engine #(
  parameter int TASK_SLOTS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  pts_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [7:0]    m_tdata,
  output logic [2:0]    m_tuser,
  output logic          m_tlast
);
  import pts_pkg::*;

  localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam int DW = 2 * TIME_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t                state;
  cmd_t                  cmd;
  logic [CW-1:0]         iss;
  logic                  p_vld;
  logic [IW-1:0]         p_idx;
  logic                  any_run;
  logic [TASK_SLOTS-1:0] used;
  logic [TASK_SLOTS-1:0] ready;

  logic                  can_emit;
  logic                  emit;
  status_t               emit_sts;
  logic [SLOT_W-1:0]     emit_slot;
  logic                  emit_last;
  logic                  stall;
  logic                  finish;
  logic                  start;
  logic                  iss_more;

  logic                  ram_we;
  logic [IW-1:0]         ram_wa;
  logic [DW-1:0]         ram_wd;
  logic                  ram_re;
  logic [DW-1:0]         ram_rd;
  logic [TIME_W-1:0]     cur_cnt;
  logic [TIME_W-1:0]     cur_per;

  logic [IW-1:0]         upd_idx;
  logic                  used_set;
  logic                  used_clr;
  logic                  rdy_set;
  logic                  rdy_clr;
  logic [TASK_SLOTS-1:0] above;
  logic                  more_ready;

  assign can_emit = !m_tvalid || m_tready;
  assign iss_more = (iss < CW'(TASK_SLOTS));
  assign cur_cnt  = ram_rd[TIME_W-1:0];
  assign cur_per  = ram_rd[DW-1:TIME_W];

  // ready slots above the one in the process stage decide tlast on dispatch
  always_comb begin
    for (int j = 0; j < TASK_SLOTS; j++) begin
      above[j] = (j > int'(p_idx));
    end
    more_ready = |(ready & above);
  end

  always_comb begin
    emit      = 1'b0;
    emit_sts  = STS_TICKED;
    emit_slot = '0;
    emit_last = 1'b1;
    finish    = 1'b0;
    start     = 1'b0;
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_wa    = p_idx;
    ram_wd    = ram_rd;
    upd_idx   = p_idx;
    used_set  = 1'b0;
    used_clr  = 1'b0;
    rdy_set   = 1'b0;
    rdy_clr   = 1'b0;

    unique case (state)
      S_IDLE: begin
        upd_idx = q_cmd.slot[IW-1:0];
        if (q_valid) begin
          if (q_cmd.op == OP_DELETE) begin
            emit     = 1'b1;
            emit_sts = STS_DELETED;
            if (can_emit) begin
              q_pop    = 1'b1;
              used_clr = q_cmd.slot_ok;
              rdy_clr  = q_cmd.slot_ok;
            end
          end else begin
            q_pop = 1'b1;
            start = 1'b1;
          end
        end
      end
      S_WALK: begin
        case (cmd.op)
          OP_CREATE: begin
            if (p_vld && !used[p_idx]) begin
              emit      = 1'b1;
              emit_sts  = STS_CREATED;
              emit_slot = SLOT_W'(p_idx);
              if (can_emit) begin
                ram_we   = 1'b1;
                ram_wd   = {cmd.period, cmd.delay};
                used_set = 1'b1;
                rdy_clr  = 1'b1;
                finish   = 1'b1;
              end
            end else if (!p_vld && !iss_more) begin
              emit     = 1'b1;
              emit_sts = STS_FULL;
              finish   = can_emit;
            end
          end
          OP_TICK: begin
            if (p_vld && used[p_idx]) begin
              ram_we = 1'b1;
              if (cur_cnt == '0) begin
                ram_wd  = {cur_per, cur_per};
                rdy_set = 1'b1;
              end else begin
                ram_wd = {cur_per, cur_cnt - TIME_W'(1)};
              end
            end else if (!p_vld && !iss_more) begin
              emit     = 1'b1;
              emit_sts = STS_TICKED;
              finish   = can_emit;
            end
          end
          default: begin
            if (p_vld && ready[p_idx]) begin
              emit      = 1'b1;
              emit_sts  = STS_RUN;
              emit_slot = SLOT_W'(p_idx);
              emit_last = !more_ready;
              if (can_emit) begin
                rdy_clr  = 1'b1;
                used_clr = (cur_per == '0);
              end
            end else if (!p_vld && !iss_more) begin
              // a dispatch with no ready slot still answers once
              emit     = !any_run;
              emit_sts = STS_IDLE;
              finish   = can_emit || any_run;
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign stall  = emit && !can_emit;
  assign ram_re = (state == S_WALK) && iss_more && !stall && !finish;

  pts_ram #(
    .WIDTH (DW),
    .DEPTH (TASK_SLOTS)
  ) u_ram (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .re  (ram_re),
    .ra  (iss[IW-1:0]),
    .rd  (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (start) begin
      cmd <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      iss     <= '0;
      p_vld   <= 1'b0;
      p_idx   <= '0;
      any_run <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state   <= S_WALK;
            iss     <= '0;
            p_vld   <= 1'b0;
            any_run <= 1'b0;
          end
        end
        S_WALK: begin
          if (finish) begin
            state <= S_IDLE;
            p_vld <= 1'b0;
          end else if (!stall) begin
            p_vld <= iss_more;
            p_idx <= iss[IW-1:0];
            if (iss_more) begin
              iss <= iss + CW'(1);
            end
          end
          if (emit && can_emit && emit_sts == STS_RUN) begin
            any_run <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      ready <= '0;
    end else begin
      if (used_set) begin
        used[upd_idx] <= 1'b1;
      end
      if (used_clr) begin
        used[upd_idx] <= 1'b0;
      end
      if (rdy_set) begin
        ready[upd_idx] <= 1'b1;
      end
      if (rdy_clr) begin
        ready[upd_idx] <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_emit) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && can_emit) begin
      m_tuser <= emit_sts;
      m_tdata <= {2'b00, emit_slot};
      m_tlast <= emit_last;
    end
  end

endmodule

// ===== hdl/pts_checker.sv =====
// port-level checks for the periodic task scheduler table
module pts_checker #(
  parameter int TASK_SLOTS = 8
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);
  import pts_pkg::*;

  // a held result keeps its contents
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // only dispatch runs span several results
  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != STS_RUN |-> m_tlast)
    else $error("non-run result without last");

  // created and run slots lie inside the table
  a_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STS_CREATED || m_tuser == STS_RUN)
      |-> m_tdata < 8'(TASK_SLOTS))
    else $error("slot outside the table");

  // an empty dispatch or a status without a slot reports slot zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STS_FULL || m_tuser == STS_DELETED
      || m_tuser == STS_TICKED || m_tuser == STS_IDLE) |-> m_tdata == 8'd0)
    else $error("nonzero slot on a slotless status");

  // nothing leaves right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result present after reset");

endmodule

bind periodic_task_scheduler_table pts_checker #(.TASK_SLOTS(TASK_SLOTS)) u_pts_checker (.*);

// ===== tb/periodic_task_scheduler_table_test.sv =====
// testbench for the periodic task scheduler table: directed and random commands, scored results
`timescale 1ns / 100ps

module periodic_task_scheduler_table_test;
  import pts_pkg::*;

  localparam int TABLE_SLOTS = 8;

  typedef struct {
    status_t    status;
    logic [5:0] task_slot;
    logic       last;
  } sched_result_t;

  // mirror of the slot table plus the results it owes
  class sched_table_model;
    bit          slot_used   [TABLE_SLOTS];
    logic [15:0] slot_period [TABLE_SLOTS];
    logic [15:0] slot_count  [TABLE_SLOTS];
    bit          slot_ready  [TABLE_SLOTS];
    sched_result_t due_results[$];
    int          failures;

    function new();
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        free_slot(i);
      end
      failures = 0;
    endfunction

    function void free_slot(int i);
      slot_used[i]   = 1'b0;
      slot_period[i] = '0;
      slot_count[i]  = '0;
      slot_ready[i]  = 1'b0;
    endfunction

    function void owe(status_t status, logic [5:0] task_slot, logic last);
      sched_result_t r;
      r.status    = status;
      r.task_slot = task_slot;
      r.last      = last;
      due_results.push_back(r);
    endfunction

    // work out what one accepted command changes and which results it causes
    function void note_command(op_t op, logic [7:0] slot, logic [15:0] period,
                               logic [15:0] delay);
      int found;
      int runs;
      found = -1;
      runs  = 0;
      case (op)
        OP_CREATE: begin
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (found < 0 && !slot_used[i]) found = i;
          end
          if (found < 0) begin
            owe(STS_FULL, '0, 1'b1);
          end else begin
            slot_used[found]   = 1'b1;
            slot_period[found] = period;
            slot_count[found]  = delay;
            slot_ready[found]  = 1'b0;
            owe(STS_CREATED, found[5:0], 1'b1);
          end
        end
        OP_DELETE: begin
          if (slot < TABLE_SLOTS) free_slot(slot);
          owe(STS_DELETED, '0, 1'b1);
        end
        OP_TICK: begin
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (slot_used[i]) begin
              if (slot_count[i] == 16'd0) begin
                slot_ready[i] = 1'b1;
                slot_count[i] = slot_period[i];
              end else begin
                slot_count[i] = slot_count[i] - 16'd1;
              end
            end
          end
          owe(STS_TICKED, '0, 1'b1);
        end
        default: begin
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (slot_ready[i]) begin
              owe(STS_RUN, i[5:0], 1'b0);
              runs++;
              slot_ready[i] = 1'b0;
              // one-shot tasks leave the table once they run
              if (slot_period[i] == 16'd0) free_slot(i);
            end
          end
          if (runs == 0) owe(STS_IDLE, '0, 1'b1);
          else due_results[due_results.size()-1].last = 1'b1;
        end
      endcase
    endfunction

    function void check_result(status_t status, logic [5:0] task_slot, logic last);
      sched_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result status %0d slot %0d last %0d", $time,
                 status, task_slot, last);
        failures++;
      end else begin
        want = due_results.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, status);
          failures++;
        end
        if (task_slot !== want.task_slot) begin
          $display("%0t: task_slot expected %0d got %0d", $time, want.task_slot,
                   task_slot);
          failures++;
        end
        if (last !== want.last) begin
          $display("%0t: last expected %0d got %0d", $time, want.last, last);
          failures++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // slot[7:0], period[23:8], delay[39:24]
  logic [1:0]  s_tuser = '0;   // func[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // task_slot[5:0], zero[7:6]
  logic [2:0]  m_tuser;        // status[2:0]
  logic        m_tlast;

  sched_table_model board = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int commands_sent = 0;

  periodic_task_scheduler_table #(
    .TASK_SLOTS(TABLE_SLOTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #4 clk = ~clk;

  initial begin
    #5_000_000;
    $display("periodic_task_scheduler_table_test failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.check_result(status_t'(m_tuser), m_tdata[5:0], m_tlast);
    end
  end

  // result side: random stalls, plus one long hold-off so the input backs up
  initial begin
    bit held;
    held = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!held && commands_sent >= 300) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_command(op_t op, logic [7:0] slot, logic [15:0] period,
                              logic [15:0] delay);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {delay, period, slot};
    do @(posedge clk); while (!s_tready);
    board.note_command(op, slot, period, delay);
    commands_sent++;
  endtask

  // short times mostly, so tasks come due often; now and then any value
  function automatic logic [15:0] pick_ticks(int short_max);
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($urandom_range(short_max));
  endfunction

  task automatic send_random_command();
    int          pick;
    logic [7:0]  slot;
    logic [15:0] period;
    logic [15:0] delay;
    pick   = $urandom_range(99);
    slot   = 8'($urandom);
    period = 16'($urandom);
    delay  = 16'($urandom);
    if (pick < 25) begin
      send_command(OP_CREATE, slot, pick_ticks(6), pick_ticks(4));
    end else if (pick < 38) begin
      if ($urandom_range(7) != 0) slot = 8'($urandom_range(TABLE_SLOTS - 1));
      send_command(OP_DELETE, slot, period, delay);
    end else if (pick < 70) begin
      send_command(OP_TICK, slot, period, delay);
    end else begin
      send_command(OP_DISPATCH, slot, period, delay);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 32;
    recv_idle_pct = 77;

    // empty table: nothing ready, tick with no tasks
    send_command(OP_DISPATCH, 8'd0, 16'd0, 16'd0);
    send_command(OP_TICK, 8'hff, 16'hffff, 16'hffff);
    // fill the table: a one-shot, the widest times, then period-1 tasks
    send_command(OP_CREATE, 8'd0, 16'd0, 16'd0);
    send_command(OP_CREATE, 8'hff, 16'hffff, 16'hffff);
    for (int i = 0; i < TABLE_SLOTS - 2; i++) begin
      send_command(OP_CREATE, 8'd0, 16'd1, 16'd0);
    end
    send_command(OP_CREATE, 8'd0, 16'd5, 16'd5);
    // out-of-range deletes are ignored
    send_command(OP_DELETE, 8'hff, 16'd0, 16'd0);
    send_command(OP_DELETE, 8'(TABLE_SLOTS), 16'd0, 16'd0);
    send_command(OP_TICK, 8'd0, 16'd0, 16'd0);
    send_command(OP_DISPATCH, 8'd0, 16'd0, 16'd0);
    // slot 0 was a one-shot and is free again
    send_command(OP_DELETE, 8'd0, 16'd0, 16'd0);
    send_command(OP_CREATE, 8'd0, 16'd0, 16'd0);
    send_command(OP_DELETE, 8'd1, 16'd0, 16'd0);
    send_command(OP_CREATE, 8'd0, 16'd2, 16'd0);
    // two ticks bring every slot due: dispatch reports the whole table
    send_command(OP_TICK, 8'd0, 16'd0, 16'd0);
    send_command(OP_TICK, 8'd0, 16'd0, 16'd0);
    send_command(OP_DISPATCH, 8'd0, 16'd0, 16'd0);
    send_command(OP_DELETE, 8'd7, 16'd0, 16'd0);
    send_command(OP_DISPATCH, 8'd0, 16'd0, 16'd0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 77;
        end
        1: begin
          send_idle_pct = 77;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (115) send_random_command();
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.failures == 0) begin
      $display("periodic_task_scheduler_table_test passed");
    end else begin
      $display("periodic_task_scheduler_table_test failed");
    end
    $finish;
  end

endmodule

// ===== periodic_task_scheduler_table.f =====
hdl/pts_pkg.sv
hdl/pts_ram.sv
hdl/pts_front.sv
hdl/pts_engine.sv
hdl/periodic_task_scheduler_table.sv
hdl/pts_checker.sv
tb/periodic_task_scheduler_table_test.sv
